FILE: rtl/core/speed_adaptive_steering_smoother_defines.svh
// Assertion macros for the steering smoother core.
// Included by the top level; no other dependencies.
`ifndef SPEED_ADAPTIVE_STEERING_SMOOTHER_DEFINES_SVH
`define SPEED_ADAPTIVE_STEERING_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS
`define SASS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SASS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SASS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SASS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/sass_pkg.sv
// Shared types and constants of the steering smoother.
// No dependencies.
package sass_pkg;

    localparam int ANGLE_W    = 15;
    localparam int SPEED_W    = 15;
    localparam int OUT_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int RUN_W      = 32;
    localparam int OPA_W      = 18;
    localparam int PROD_W     = OPA_W + RUN_W;
    localparam int QUO_W      = 15;
    localparam int QCNT_W     = $clog2(QUO_W);
    localparam int GAIN_W     = 17;
    localparam int GAIN_BASE  = 52429;
    localparam int RES_MAX    = 19661;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd49152;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FOLD = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_GAIN = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

endpackage

FILE: rtl/core/sass_if.sv
// Handshake channels of the steering smoother: input, result and weight write.
// Depends on sass_pkg.
interface sass_in_if import sass_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] raw_angle;
    logic signed [SPEED_W-1:0] speed;
    modport source (output valid, output raw_angle, output speed, input ready);
    modport sink   (input valid, input raw_angle, input speed, output ready);
endinterface

interface sass_out_if import sass_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] smoothed_angle;
    modport source (output valid, output smoothed_angle, input ready);
    modport sink   (input valid, input smoothed_angle, output ready);
endinterface

interface sass_cfg_if import sass_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/speed_adaptive_steering_smoother.sv
// Speed-adaptive steering smoother: EMA over recent angles with a speed gain.
// Depends on sass_pkg, sass_if and the defines header.
//
//   channel  dir  payload                  transaction when
//   i_in     in   raw_angle, speed         valid & ready
//   o_out    out  smoothed_angle           valid & ready
//   i_cfg    in   data (smoothing weight)  valid & ready (ready always high)
//
// The first item after reset is passed through from ST_IDLE via ST_DONE to the output register.
// Later items are folded over the angle history in ST_FOLD and checked in ST_CHK; with gain
// they also take a 15-bit quotient from the divider in ST_DIV and one gain multiply in ST_GAIN.
// The one 18x32 multiplier does every fold step and the gain. Reset is synchronous.
// A new item is taken while a result waits in the output register.
`include "speed_adaptive_steering_smoother_defines.svh"

module speed_adaptive_steering_smoother
    import sass_pkg::*;
#(
    parameter int ANGLE_TAPS = 5,
    parameter int SPEED_TAPS = 3
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sass_in_if.sink    i_in,
    sass_out_if.source o_out,
    sass_cfg_if.sink   i_cfg
);

    localparam int AHD   = ANGLE_TAPS - 1;
    localparam int SHD   = SPEED_TAPS - 1;
    localparam int LOOPS = (AHD > SHD) ? AHD : SHD;
    localparam int CW    = (LOOPS > 1) ? $clog2(LOOPS) : 1;
    localparam int AIW   = (AHD > 1) ? $clog2(AHD) : 1;
    localparam int SUMW  = SPEED_W + 1 + $clog2(SPEED_TAPS);
    localparam int THR   = 1280 * SPEED_TAPS;
    localparam int CAP   = 3072 * SPEED_TAPS;
    localparam int NUM   = 512 * SPEED_TAPS * 65536;
    localparam int CPW   = $clog2(CAP + 1);
    localparam int DVW   = $clog2(NUM) + 2;

    t_state                     r_state;
    logic                       r_started;
    logic [WEIGHT_W-1:0]        r_weight;
    logic signed [ANGLE_W-1:0]  r_ang_hist [AHD];
    logic signed [ANGLE_W-1:0]  r_raw;
    logic signed [SPEED_W-1:0]  r_spd;
    logic signed [RUN_W-1:0]    r_run;
    logic signed [SUMW-1:0]     r_sum;
    logic [CW-1:0]              r_cnt;
    logic [DVW-1:0]             r_rem;
    logic [DVW-1:0]             r_dvs;
    logic [QUO_W-1:0]           r_q;
    logic [QCNT_W-1:0]          r_qcnt;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [OUT_W-1:0]    r_res;
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_data;

    logic signed [ANGLE_W-1:0]  w_hist;
    logic signed [SPEED_W-1:0]  w_stap;
    logic signed [RUN_W-1:0]    w_hs;
    logic signed [RUN_W-1:0]    w_diff;
    logic signed [OPA_W-1:0]    w_opa;
    logic signed [RUN_W-1:0]    w_opb;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_rnd;
    logic signed [PROD_W-1:0]   w_psum;
    logic signed [RUN_W-1:0]    w_fold;
    logic signed [RUN_W-1:0]    w_nog;
    logic                       w_fold_en;
    logic                       w_gain_on;
    logic [CPW-1:0]             w_capped;
    logic                       w_ge;
    logic [QUO_W-1:0]           w_qn;
    logic                       w_in_acc;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.smoothed_angle = r_out_data;

    // shared multiplier: fold step a*(run - h) or final gain*run
    assign w_hist    = r_ang_hist[r_cnt[AIW-1:0]];
    assign w_fold_en = (int'(r_cnt) < AHD);
    assign w_hs      = {{(RUN_W - ANGLE_W - 16){w_hist[ANGLE_W-1]}}, w_hist, 16'd0};
    assign w_diff    = r_run - w_hs;

    always_comb begin
        if (r_state == ST_GAIN) begin
            w_opa = $signed({1'b0, r_gain});
            w_opb = r_run;
            w_rnd = PROD_W'(64'sd1 <<< 31);
        end else begin
            w_opa = $signed({2'b00, r_weight});
            w_opb = w_diff;
            w_rnd = PROD_W'(64'sd32768);
        end
    end

    assign w_prod = w_opa * w_opb;
    assign w_psum = w_prod + w_rnd;
    assign w_fold = w_hs + $signed(w_psum[47:16]);
    assign w_nog  = r_run + 32'sd32768;

    assign w_gain_on = (r_sum > $signed(SUMW'(THR)));
    assign w_capped  = (r_sum > $signed(SUMW'(CAP))) ? CPW'(CAP) : r_sum[CPW-1:0];
    assign w_ge      = (r_rem >= r_dvs);
    assign w_qn      = {r_q[QUO_W-2:0], w_ge};

    generate
        if (SPEED_TAPS > 1) begin : g_spd
            localparam int SIW = (SHD > 1) ? $clog2(SHD) : 1;
            logic signed [SPEED_W-1:0] r_spd_hist [SHD];

            assign w_stap = (int'(r_cnt) < SHD) ? r_spd_hist[r_cnt[SIW-1:0]] : '0;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int i = 0; i < SHD; i++) r_spd_hist[i] <= '0;
                end else if (r_state == ST_CHK) begin
                    for (int i = 0; i < SHD - 1; i++) r_spd_hist[i] <= r_spd_hist[i+1];
                    r_spd_hist[SHD-1] <= r_spd;
                end
            end
        end else begin : g_nospd
            assign w_stap = '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RST;
        end else if (i_cfg.valid) begin
            r_weight <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AHD; i++) r_ang_hist[i] <= '0;
        end else begin
            if ((r_state == ST_DONE) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_raw <= i_in.raw_angle;
                        r_spd <= i_in.speed;
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_res     <= OUT_W'(i_in.raw_angle);
                            r_state   <= ST_DONE;
                        end else begin
                            r_run   <= {{(RUN_W - ANGLE_W - 16){i_in.raw_angle[ANGLE_W-1]}},
                                        i_in.raw_angle, 16'd0};
                            r_sum   <= SUMW'(i_in.speed);
                            r_cnt   <= CW'(LOOPS - 1);
                            r_state <= ST_FOLD;
                        end
                    end
                end
                ST_FOLD: begin
                    if (w_fold_en) r_run <= w_fold;
                    r_sum <= r_sum + SUMW'(w_stap);
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= ST_CHK;
                end
                ST_CHK: begin
                    for (int i = 0; i < AHD - 1; i++) r_ang_hist[i] <= r_ang_hist[i+1];
                    r_ang_hist[AHD-1] <= r_raw;
                    if (w_gain_on) begin
                        r_rem   <= DVW'(NUM) + DVW'(w_capped >> 1);
                        r_dvs   <= DVW'(w_capped) << (QUO_W - 1);
                        r_q     <= '0;
                        r_qcnt  <= QCNT_W'(QUO_W - 1);
                        r_state <= ST_DIV;
                    end else begin
                        r_res   <= w_nog[31:16];
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (w_ge) r_rem <= r_rem - r_dvs;
                    r_dvs  <= r_dvs >> 1;
                    r_q    <= w_qn;
                    r_qcnt <= r_qcnt - 1'b1;
                    if (r_qcnt == '0) begin
                        r_gain  <= GAIN_W'(GAIN_BASE) + GAIN_W'(w_qn);
                        r_state <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    r_res   <= w_psum[47:32];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_data  <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SASS_ASSERT_NEXT(a_started_goes_fold, i_clk, i_rst_n, w_in_acc && r_started,
        r_state == ST_FOLD, "started transaction did not enter fold")
    `SASS_ASSERT_SAME(a_div_rem_bound, i_clk, i_rst_n, r_state == ST_DIV,
        {1'b0, r_rem} < {r_dvs, 1'b0}, "divider remainder out of range")
    `SASS_ASSERT_SAME(a_result_range, i_clk, i_rst_n, r_state == ST_DONE,
        (r_res <= $signed(OUT_W'(RES_MAX))) && (r_res >= -$signed(OUT_W'(RES_MAX))),
        "result exceeds gain range")

endmodule

FILE: bench/speed_adaptive_steering_smoother_tb.sv
// Self-checking bench for the speed-adaptive steering smoother: a directed table,
// then randomized phases per smoothing weight, scored against a local predictor or typed results.
// Depends on sass_pkg, the sass_*_if interfaces and the speed_adaptive_steering_smoother RTL.
`timescale 1ns / 1ps

module speed_adaptive_steering_smoother_tb;
    import sass_pkg::*;

    localparam longint SPEED_FLOOR = 1280 * 3;
    localparam longint SPEED_CAP   = 3072 * 3;
    localparam longint GAIN_NUM    = 512 * 3 * 65536;
    localparam int     PHASES      = 7;
    localparam int     PHASE_ITEMS = 250;
    localparam int     HOLD_AT     = 700;
    localparam int     HOLD_LEN    = 400;
    localparam int     DRAIN_WAIT  = 40;

    typedef enum {ROW_ITEM, ROW_WEIGHT} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [WEIGHT_W-1:0]       weight;
        logic signed [ANGLE_W-1:0] raw;
        logic signed [SPEED_W-1:0] spd;
        bit                        typed;
        logic signed [OUT_W-1:0]   result;
    } t_stim_row;

    localparam int DIR_ROWS = 25;

    t_stim_row dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd16383, 1'b1, -16'sd16384},
        '{ROW_ITEM,   16'd0,      15'sd16383,  15'sd16383, 1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384, -15'sd16384, 1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd16383,  15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd1281,  1'b0,  16'sd0},
        '{ROW_WEIGHT, 16'd0,      15'sd0,      15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd100,    15'sd0,     1'b1,  16'sd16383},
        '{ROW_ITEM,   16'd0,     -15'sd200,    15'sd0,     1'b1, -16'sd16384},
        '{ROW_ITEM,   16'd0,      15'sd300,    15'sd0,     1'b1,  16'sd16383},
        '{ROW_ITEM,   16'd0,     -15'sd400,    15'sd0,     1'b1, -16'sd16384},
        '{ROW_ITEM,   16'd0,      15'sd500,    15'sd0,     1'b1,  16'sd100},
        '{ROW_WEIGHT, 16'hFFFF,   15'sd0,      15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd7,      15'sd1280,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd4095,   15'sd1280,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd4096,   15'sd1280,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd8191,   15'sd1281,  1'b0,  16'sd0},
        '{ROW_WEIGHT, 16'd1,      15'sd0,      15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd3072,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd3072,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd3072,  1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd16384,  15'sd3073,  1'b0,  16'sd0},
        '{ROW_WEIGHT, 16'h8000,   15'sd0,      15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd0,      15'sd0,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,      15'sd16383, -15'sd1,     1'b0,  16'sd0},
        '{ROW_ITEM,   16'd0,     -15'sd1,      15'sd16383, 1'b0,  16'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    sass_in_if  in_ch ();
    sass_out_if out_ch ();
    sass_cfg_if cfg_ch ();

    speed_adaptive_steering_smoother dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state
    logic signed [ANGLE_W-1:0] angle_hist [4];
    logic signed [SPEED_W-1:0] speed_hist [2];
    bit                        primed;
    logic [WEIGHT_W-1:0]       weight_q;

    logic signed [OUT_W-1:0] smoothed_q [$];
    logic signed [OUT_W-1:0] want;
    int                      fail_count;
    int                      results_seen;
    bit                      no_idle;
    bit                      held_once;
    int                      hold_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("speed_adaptive_steering_smoother_tb NOT OK");
        $finish;
    end

    function automatic logic signed [OUT_W-1:0] predict_smoothed(
        input logic signed [ANGLE_W-1:0] raw,
        input logic signed [SPEED_W-1:0] spd
    );
        longint run, h, wt, sum, capped, gain, res;
        int     i;
        res = raw;
        if (!primed) begin
            primed = 1'b1;
            return res[OUT_W-1:0];
        end
        wt  = weight_q;
        run = raw;
        run = run * 65536;
        for (i = 3; i >= 0; i--) begin
            h   = angle_hist[i];
            h   = h * 65536;
            run = (wt * run + (65536 - wt) * h + 32768) >>> 16;
        end
        sum = spd;
        h   = speed_hist[0];
        sum = sum + h;
        h   = speed_hist[1];
        sum = sum + h;
        if (sum > SPEED_FLOOR) begin
            capped = (sum > SPEED_CAP) ? SPEED_CAP : sum;
            gain   = GAIN_BASE + (GAIN_NUM + capped / 2) / capped;
            res    = (run * gain + (longint'(1) <<< 31)) >>> 32;
        end else begin
            res = (run + 32768) >>> 16;
        end
        for (i = 0; i < 3; i++) angle_hist[i] = angle_hist[i + 1];
        angle_hist[3] = raw;
        speed_hist[0] = speed_hist[1];
        speed_hist[1] = spd;
        return res[OUT_W-1:0];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int m;
        m = $urandom_range(9);
        if (m == 0) return $urandom_range(1) ? 15'sd16383 : -15'sd16384;
        if (m == 1) return 15'($urandom_range(200)) - 15'sd100;
        return 15'($urandom());
    endfunction

    function automatic logic signed [SPEED_W-1:0] rand_speed();
        int m;
        m = $urandom_range(9);
        if (m <= 3) return 15'($urandom_range(2600));
        if (m <= 5) return 15'($urandom_range(3400, 2800));
        if (m <= 7) return 15'($urandom());
        if (m == 8) return -15'($urandom_range(2000));
        return $urandom_range(1) ? 15'sd16383 : -15'sd16384;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(
        input logic signed [ANGLE_W-1:0] raw,
        input logic signed [SPEED_W-1:0] spd,
        input bit                        typed,
        input logic signed [OUT_W-1:0]   typed_val
    );
        logic signed [OUT_W-1:0] exp_val;
        while (!no_idle && $urandom_range(99) < 19) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.raw_angle = raw;
        in_ch.speed     = spd;
        do @(posedge i_clk); while (!in_ch.ready);
        exp_val = predict_smoothed(raw, spd);
        if (typed) exp_val = typed_val;
        smoothed_q = {smoothed_q, exp_val};
        @(negedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        in_ch.valid = 1'b0;
        while (smoothed_q.size() != 0) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        weight_q = w;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_once && results_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left    = hold_left - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = no_idle || ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (smoothed_q.size() == 0) begin
                $error("smoothed_angle: expected none, actual %0d", out_ch.smoothed_angle);
                fail_count++;
            end else begin
                want = smoothed_q[0];
                smoothed_q.delete(0);
                if (out_ch.smoothed_angle !== want) begin
                    $error("smoothed_angle: expected %0d, actual %0d",
                           want, out_ch.smoothed_angle);
                    fail_count++;
                end
            end
            results_seen++;
        end
    end

    initial begin
        logic [WEIGHT_W-1:0] w;
        in_ch.valid     = 1'b0;
        in_ch.raw_angle = '0;
        in_ch.speed     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        fail_count      = 0;
        results_seen    = 0;
        no_idle         = 1'b0;
        held_once       = 1'b0;
        hold_left       = 0;
        primed          = 1'b0;
        weight_q        = WEIGHT_RST;
        for (int i = 0; i < 4; i++) angle_hist[i] = '0;
        for (int i = 0; i < 2; i++) speed_hist[i] = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_WEIGHT) begin
                write_weight(dir_rows[r].weight);
            end else begin
                send_item(dir_rows[r].raw, dir_rows[r].spd,
                          dir_rows[r].typed, dir_rows[r].result);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       w = '0;
                1:       w = 16'hFFFF;
                2:       w = 16'd1;
                3:       w = 16'h8000;
                6:       w = WEIGHT_RST;
                default: w = 16'($urandom());
            endcase
            write_weight(w);
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_item(rand_angle(), rand_speed(), 1'b0, '0);
            end
        end
        no_idle     = 1'b0;
        in_ch.valid = 1'b0;

        while (smoothed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && smoothed_q.size() == 0) begin
            $display("speed_adaptive_steering_smoother_tb OK");
        end else begin
            $display("speed_adaptive_steering_smoother_tb NOT OK");
        end
        $finish;
    end

endmodule
